// File: src/mtep_pkg.sv
// Shared types, constants and helpers for the MIDI track event parser.
// Used by every module of the parser; depends on nothing else.
package mtep_pkg;

    // Field widths fixed by the event format.
    localparam int BYTE_W = 8;
    localparam int DATA7_W = 7;
    localparam int LEN_W = 28;
    localparam int VLQ_BITS = 7;
    localparam int KIND_W = 2;
    localparam int ERR_W = 3;
    localparam int CNT_W = 3;

    // Longest variable-length count accepted, in bytes.
    localparam int MAX_LENGTH_BYTES = 4;

    // Mask of the status high nibble and the size of a three-byte message.
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam int THREE_BYTE_MSG = 3;

    // Record kinds.
    localparam logic [KIND_W-1:0] KIND_CHANNEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_STATUS = 3'd1;
    localparam logic [ERR_W-1:0] ERR_COUNT_LONG = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_RUNNING = 3'd4;

    // Special status bytes.
    localparam logic [BYTE_W-1:0] STATUS_META = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_SYSEX = 8'hF0;
    localparam logic [BYTE_W-1:0] STATUS_ESCAPE = 8'hF7;
    localparam logic [BYTE_W-1:0] STATUS_SYSTEM = 8'hF0;

    // High nibbles of the one-data-byte channel messages.
    localparam logic [3:0] NIB_PROGRAM = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_WAIT    = 6'b000001,
        PH_DATA1   = 6'b000010,
        PH_DATA2   = 6'b000100,
        PH_TYPE    = 6'b001000,
        PH_LEN     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    // One input byte as held in the input register.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              chunk_end;
    } item_t;

    // One result record.
    typedef struct packed {
        logic [KIND_W-1:0]  record_kind;
        logic [BYTE_W-1:0]  status;
        logic [BYTE_W-1:0]  first_data;
        logic [DATA7_W-1:0] second_data;
        logic               has_second;
        logic [LEN_W-1:0]   payload_length;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last;
        logic [ERR_W-1:0]   error_code;
    } record_t;

    // True when a channel status carries two data bytes.
    function automatic logic is_three_byte(input logic [BYTE_W-1:0] st);
        logic [3:0] hi;
        hi = st[7:4] & NIBBLE_MASK;
        return !((hi == NIB_PROGRAM) || (hi == NIB_PRESSURE));
    endfunction

endpackage

// File: src/mtep_in_stage.sv
// Input register of the MIDI track event parser: holds one request byte.
// Depends on mtep_pkg.
module mtep_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  logic [7:0]       byte_value,
    input  logic             chunk_end,
    input  logic             advance,
    output logic             item_valid,
    output mtep_pkg::item_t  item
);

    logic            valid_reg;
    logic            valid_next;
    mtep_pkg::item_t item_reg;
    logic            load;

    // Hold the request while the held byte cannot move on.
    assign byte_stall = valid_reg && !advance;
    assign load = byte_valid && !byte_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.byte_value <= byte_value;
            item_reg.chunk_end <= chunk_end;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// File: src/mtep_parse_core.sv
// Parse state and per-byte decode of the MIDI track event parser.
// Depends on mtep_pkg.
module mtep_parse_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  mtep_pkg::item_t   item,
    output logic              has_rec,
    output mtep_pkg::record_t rec
);

    localparam int LW = mtep_pkg::LEN_W;
    localparam int BW = mtep_pkg::BYTE_W;

    mtep_pkg::phase_t     phase_reg, phase_next;
    logic [BW-1:0]        running_reg, running_next;
    logic [BW-1:0]        current_reg, current_next;
    logic [BW-1:0]        held_reg, held_next;
    logic [LW-1:0]        acc_reg, acc_next;
    logic [mtep_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [LW-1:0]        remain_reg, remain_next;

    // Decode of the held byte against the current phase.
    always_comb
    begin
        logic [BW-1:0]  b;
        logic           last_byte;
        logic           do_take;
        logic [BW-1:0]  take_st;
        logic           do_fail;
        logic [BW-1:0]  fail_st;
        logic [mtep_pkg::ERR_W-1:0] fail_err;
        logic [LW-1:0]  acc_new;
        logic [mtep_pkg::CNT_W-1:0] cnt_new;
        logic [LW-1:0]  remain_dec;

        b = item.byte_value;
        last_byte = item.chunk_end;
        do_take = 1'b0;
        take_st = current_reg;
        do_fail = 1'b0;
        fail_st = '0;
        fail_err = mtep_pkg::ERR_NONE;
        acc_new = {acc_reg[LW-mtep_pkg::VLQ_BITS-1:0], b[mtep_pkg::VLQ_BITS-1:0]};
        cnt_new = cnt_reg + 1'b1;
        remain_dec = (remain_reg != '0) ? (remain_reg - 1'b1) : remain_reg;

        phase_next = phase_reg;
        running_next = running_reg;
        current_next = current_reg;
        held_next = held_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        remain_next = remain_reg;
        has_rec = 1'b0;
        rec = '0;

        unique case (phase_reg)
            mtep_pkg::PH_WAIT:
            begin
                if (!b[7])
                begin
                    // Data byte: fall back on running status.
                    if (running_reg == '0)
                    begin
                        do_fail = 1'b1;
                        fail_st = '0;
                        fail_err = mtep_pkg::ERR_NO_RUNNING;
                    end
                    else
                    begin
                        current_next = running_reg;
                        take_st = running_reg;
                        do_take = 1'b1;
                    end
                end
                else if (b < mtep_pkg::STATUS_SYSTEM)
                begin
                    // Channel status byte.
                    current_next = b;
                    running_next = b;
                    if (last_byte)
                    begin
                        do_fail = 1'b1;
                        fail_st = b;
                        fail_err = mtep_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_DATA1;
                    end
                end
                else if ((b == mtep_pkg::STATUS_META) || (b == mtep_pkg::STATUS_SYSEX)
                         || (b == mtep_pkg::STATUS_ESCAPE))
                begin
                    // Meta or sysex event start.
                    current_next = b;
                    running_next = '0;
                    held_next = '0;
                    acc_next = '0;
                    cnt_next = '0;
                    if (last_byte)
                    begin
                        do_fail = 1'b1;
                        fail_st = b;
                        fail_err = mtep_pkg::ERR_TRUNCATED;
                    end
                    else if (b == mtep_pkg::STATUS_META)
                    begin
                        phase_next = mtep_pkg::PH_TYPE;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_LEN;
                    end
                end
                else
                begin
                    current_next = b;
                    do_fail = 1'b1;
                    fail_st = b;
                    fail_err = mtep_pkg::ERR_BAD_STATUS;
                end
            end
            mtep_pkg::PH_DATA1:
            begin
                do_take = 1'b1;
            end
            mtep_pkg::PH_DATA2:
            begin
                phase_next = mtep_pkg::PH_WAIT;
                has_rec = 1'b1;
                rec.record_kind = mtep_pkg::KIND_CHANNEL;
                rec.status = current_reg;
                rec.first_data = held_reg;
                rec.second_data = b[mtep_pkg::DATA7_W-1:0];
                rec.has_second = 1'b1;
                rec.last = 1'b1;
            end
            mtep_pkg::PH_TYPE:
            begin
                if (last_byte)
                begin
                    do_fail = 1'b1;
                    fail_st = current_reg;
                    fail_err = mtep_pkg::ERR_TRUNCATED;
                end
                else
                begin
                    held_next = b;
                    phase_next = mtep_pkg::PH_LEN;
                end
            end
            mtep_pkg::PH_LEN:
            begin
                acc_next = acc_new;
                cnt_next = cnt_new;
                if (b[7])
                begin
                    // Count continues.
                    if (cnt_new >= mtep_pkg::CNT_W'(mtep_pkg::MAX_LENGTH_BYTES))
                    begin
                        do_fail = 1'b1;
                        fail_st = current_reg;
                        fail_err = mtep_pkg::ERR_COUNT_LONG;
                    end
                    else if (last_byte)
                    begin
                        do_fail = 1'b1;
                        fail_st = current_reg;
                        fail_err = mtep_pkg::ERR_TRUNCATED;
                    end
                end
                else if (acc_new == '0)
                begin
                    // Empty event completes with its header.
                    phase_next = mtep_pkg::PH_WAIT;
                    has_rec = 1'b1;
                    rec.record_kind = mtep_pkg::KIND_HEADER;
                    rec.status = current_reg;
                    rec.first_data = held_reg;
                    rec.last = 1'b1;
                end
                else if (last_byte)
                begin
                    do_fail = 1'b1;
                    fail_st = current_reg;
                    fail_err = mtep_pkg::ERR_TRUNCATED;
                end
                else
                begin
                    remain_next = acc_new;
                    phase_next = mtep_pkg::PH_PAYLOAD;
                    has_rec = 1'b1;
                    rec.record_kind = mtep_pkg::KIND_HEADER;
                    rec.status = current_reg;
                    rec.first_data = held_reg;
                    rec.payload_length = acc_new;
                end
            end
            mtep_pkg::PH_PAYLOAD:
            begin
                remain_next = remain_dec;
                if ((remain_dec != '0) && last_byte)
                begin
                    do_fail = 1'b1;
                    fail_st = current_reg;
                    fail_err = mtep_pkg::ERR_TRUNCATED;
                end
                if (remain_dec == '0)
                begin
                    phase_next = mtep_pkg::PH_WAIT;
                end
                has_rec = 1'b1;
                rec.record_kind = mtep_pkg::KIND_PAYLOAD;
                rec.status = current_reg;
                rec.first_data = held_reg;
                rec.payload_length = acc_reg;
                rec.payload_byte = b;
                rec.last = (remain_dec == '0);
            end
            default:
            begin
                phase_next = mtep_pkg::PH_WAIT;
            end
        endcase

        // First data byte of a channel message.
        if (do_take)
        begin
            if (mtep_pkg::is_three_byte(take_st))
            begin
                if (last_byte)
                begin
                    do_fail = 1'b1;
                    fail_st = take_st;
                    fail_err = mtep_pkg::ERR_TRUNCATED;
                end
                else
                begin
                    held_next = b;
                    phase_next = mtep_pkg::PH_DATA2;
                end
            end
            else
            begin
                phase_next = mtep_pkg::PH_WAIT;
                has_rec = 1'b1;
                rec.record_kind = mtep_pkg::KIND_CHANNEL;
                rec.status = take_st;
                rec.first_data = b;
                rec.last = 1'b1;
            end
        end

        // An error replaces any other record and drops running status.
        if (do_fail)
        begin
            running_next = '0;
            phase_next = mtep_pkg::PH_WAIT;
            acc_next = '0;
            cnt_next = '0;
            remain_next = '0;
            has_rec = 1'b1;
            rec = '0;
            rec.record_kind = mtep_pkg::KIND_ERROR;
            rec.status = fail_st;
            rec.last = 1'b1;
            rec.error_code = fail_err;
        end
    end

    // Parse state advances once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mtep_pkg::PH_WAIT;
            running_reg <= '0;
            current_reg <= '0;
            held_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            remain_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            running_reg <= running_next;
            current_reg <= current_next;
            held_reg <= held_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// File: src/mtep_out_stage.sv
// Result register of the MIDI track event parser, driving the record port.
// Depends on mtep_pkg.
module mtep_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mtep_pkg::record_t rec_in,
    output logic              out_free,
    output logic              record_valid,
    input  logic              record_stall,
    output logic [1:0]        record_kind,
    output logic [7:0]        status,
    output logic [7:0]        first_data,
    output logic [6:0]        second_data,
    output logic              has_second,
    output logic [27:0]       payload_length,
    output logic [7:0]        payload_byte,
    output logic              last,
    output logic [2:0]        error_code
);

    logic              valid_reg;
    logic              valid_next;
    mtep_pkg::record_t rec_reg;

    // Free when empty or when the held record leaves this cycle.
    assign out_free = !valid_reg || !record_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (record_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
        end
    end

    assign record_valid = valid_reg;
    assign record_kind = rec_reg.record_kind;
    assign status = rec_reg.status;
    assign first_data = rec_reg.first_data;
    assign second_data = rec_reg.second_data;
    assign has_second = rec_reg.has_second;
    assign payload_length = rec_reg.payload_length;
    assign payload_byte = rec_reg.payload_byte;
    assign last = rec_reg.last;
    assign error_code = rec_reg.error_code;

endmodule

// File: src/midi_track_event_parser_unit.sv
// MIDI track event parser: one track byte in, at most one record out per byte.
// A byte is held in the input register, and its record is then registered in the result register.
// Throughput: one byte per cycle while the record side does not stall; the
// input register and the result register bound the path, and the parse state
// updates once per byte. Reset (rst_n low, asynchronous) empties both registers
// and returns the parser to waiting for a status byte with no running status.
module midi_track_event_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_value,
    input  logic        chunk_end,
    output logic        record_valid,
    input  logic        record_stall,
    output logic [1:0]  record_kind,
    output logic [7:0]  status,
    output logic [7:0]  first_data,
    output logic [6:0]  second_data,
    output logic        has_second,
    output logic [27:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        last,
    output logic [2:0]  error_code
);

    logic              item_valid;
    mtep_pkg::item_t   item;
    logic              has_rec;
    mtep_pkg::record_t rec;
    logic              out_free;
    logic              advance;
    logic              load;

    // A held byte moves on when it makes no record or the result slot is free.
    assign advance = item_valid && (!has_rec || out_free);
    assign load = advance && has_rec;

    mtep_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_value (byte_value),
        .chunk_end  (chunk_end),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mtep_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .has_rec (has_rec),
        .rec     (rec)
    );

    mtep_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .rec_in         (rec),
        .out_free       (out_free),
        .record_valid   (record_valid),
        .record_stall   (record_stall),
        .record_kind    (record_kind),
        .status         (status),
        .first_data     (first_data),
        .second_data    (second_data),
        .has_second     (has_second),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .last           (last),
        .error_code     (error_code)
    );

endmodule

// File: src/mtep_checker.sv
// Port-level checks for the MIDI track event parser, bound to its top level.
// Depends on mtep_pkg and midi_track_event_parser_unit.
module mtep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  byte_value,
    input logic        chunk_end,
    input logic        record_valid,
    input logic        record_stall,
    input logic [1:0]  record_kind,
    input logic [7:0]  status,
    input logic [7:0]  first_data,
    input logic [6:0]  second_data,
    input logic        has_second,
    input logic [27:0] payload_length,
    input logic [7:0]  payload_byte,
    input logic        last,
    input logic [2:0]  error_code
);

    // A stalled record stays, and its kind, status, payload byte and last flag do not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && record_stall |=> record_valid && $stable(record_kind)
        && $stable(status) && $stable(payload_byte) && $stable(last))
        else $error("stalled record changed");

    // Errors close the event and carry a code.
    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && (record_kind == mtep_pkg::KIND_ERROR)
        |-> last && (error_code != mtep_pkg::ERR_NONE))
        else $error("error record without code or last");

    // Only error records carry a code.
    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && (record_kind != mtep_pkg::KIND_ERROR)
        |-> (error_code == mtep_pkg::ERR_NONE))
        else $error("error code on a normal record");

    // Channel messages complete in one record.
    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && (record_kind == mtep_pkg::KIND_CHANNEL) |-> last)
        else $error("channel message without last");

    // Payload bytes belong to an event with a nonzero count.
    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && (record_kind == mtep_pkg::KIND_PAYLOAD)
        |-> (payload_length != '0))
        else $error("payload byte with zero length");

endmodule

bind midi_track_event_parser_unit mtep_checker u_checker (.*);
